[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the kinematics core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define DRI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, masked while reset is high
`define DRI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset
`define DRI_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

[rtl/core/dri_pkg.sv]
// Types, constants and tables of the delta robot inverse kinematics core
package dri_pkg;

  localparam int COORD_FRAC_BITS = 8;

  localparam int LEN_W  = 19;
  localparam int PPR_W  = 20;
  localparam int POS_W  = 20;
  localparam int ANG_W  = 19;
  localparam int PUL_W  = 20;

  localparam int ROOT_W = 44;
  localparam int RAD_W  = 88;
  localparam int P_W    = 46;
  localparam int TWOA_W = 41;
  localparam int NORM_W = 59;
  localparam int CX_W   = 64;
  localparam int PHI_W  = 25;
  localparam int CORDIC_STEPS = 20;

  localparam logic [ANG_W-1:0] FULL_TURN_Q = 19'd368640;

  // Pulse scaling: angle * ppr / 368640 = ((angle * ppr) >> 13) / 45
  localparam int          PUL_SHIFT = 13;
  localparam logic [26:0] DIV_RECIP = 27'd95443717;
  localparam logic [26:0] DIV_CONST = 27'd45;

  localparam logic [LEN_W-1:0] RST_ACTIVE   = LEN_W'(515 << (COORD_FRAC_BITS - 1));
  localparam logic [LEN_W-1:0] RST_PASSIVE  = LEN_W'(548 << COORD_FRAC_BITS);
  localparam logic [LEN_W-1:0] RST_BASE     = LEN_W'(190 << COORD_FRAC_BITS);
  localparam logic [LEN_W-1:0] RST_PLATFORM = LEN_W'(62 << COORD_FRAC_BITS);
  localparam logic [PPR_W-1:0] RST_PPR      = 20'd200000;

  typedef enum logic [2:0] {
    CFG_ACTIVE   = 3'd0,
    CFG_PASSIVE  = 3'd1,
    CFG_BASE     = 3'd2,
    CFG_PLATFORM = 3'd3,
    CFG_PPR      = 3'd4
  } cfg_idx_t;

  typedef logic [1:0] arm_t;
  localparam arm_t ARM_ONE   = 2'd0;
  localparam arm_t ARM_TWO   = 2'd1;
  localparam arm_t ARM_THREE = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [LEN_W-1:0] active;
    logic [LEN_W-1:0] passive;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] platform;
    logic [PPR_W-1:0] ppr;
  } cfg_t;

  typedef struct packed {
    arm_t arm;
    logic fail;
  } tag_t;

  typedef struct packed {
    tag_t                     tag;
    logic signed [P_W-1:0]    den;
    logic signed [TWOA_W-1:0] twoa;
  } root_side_t;

  function automatic logic signed [17:0] cos_q16(arm_t a);
    case (a)
      ARM_ONE: cos_q16 = 18'sd56756;
      ARM_TWO: cos_q16 = -18'sd56756;
      default: cos_q16 = 18'sd0;
    endcase
  endfunction

  function automatic logic signed [17:0] sin_q16(arm_t a);
    case (a)
      ARM_ONE: sin_q16 = 18'sd32768;
      ARM_TWO: sin_q16 = 18'sd32768;
      default: sin_q16 = -18'sd65536;
    endcase
  endfunction

  // atan(2^-i) in 1/65536 degree
  function automatic logic [PHI_W-1:0] atan_q16(int i);
    case (i)
      0:  atan_q16 = 25'd2949120;
      1:  atan_q16 = 25'd1740967;
      2:  atan_q16 = 25'd919879;
      3:  atan_q16 = 25'd466945;
      4:  atan_q16 = 25'd234379;
      5:  atan_q16 = 25'd117304;
      6:  atan_q16 = 25'd58666;
      7:  atan_q16 = 25'd29335;
      8:  atan_q16 = 25'd14668;
      9:  atan_q16 = 25'd7334;
      10: atan_q16 = 25'd3667;
      11: atan_q16 = 25'd1833;
      12: atan_q16 = 25'd917;
      13: atan_q16 = 25'd458;
      14: atan_q16 = 25'd229;
      15: atan_q16 = 25'd115;
      16: atan_q16 = 25'd57;
      17: atan_q16 = 25'd29;
      18: atan_q16 = 25'd14;
      19: atan_q16 = 25'd7;
      default: atan_q16 = 25'd0;
    endcase
  endfunction

endpackage

[rtl/core/delta_robot_inverse_kinematics.sv]
// Delta robot inverse kinematics core, top level
// Flow: an accepted position waits in the queue while earlier positions are in issue; then
// its three arms enter the shared arm pipeline in turn, and done rises when the third is collected.
// The shared arm pipeline takes one arm per cycle; the next position is popped as a last arm issues.
// A two-entry queue takes starts on consecutive cycles; busy rises when it is full.
// Reset: synchronous, clears queue, pipeline valids and strobe, loads default geometry.
module delta_robot_inverse_kinematics (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [dri_pkg::POS_W-1:0] x_pos,
  input  logic signed [dri_pkg::POS_W-1:0] y_pos,
  input  logic signed [dri_pkg::POS_W-1:0] z_pos,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [dri_pkg::PPR_W-1:0]  cfg_data,
  output logic                       done,
  output logic [dri_pkg::ANG_W-1:0]  angle_one,
  output logic [dri_pkg::ANG_W-1:0]  angle_two,
  output logic [dri_pkg::ANG_W-1:0]  angle_three,
  output logic [dri_pkg::PUL_W-1:0]  pulses_one,
  output logic [dri_pkg::PUL_W-1:0]  pulses_two,
  output logic [dri_pkg::PUL_W-1:0]  pulses_three,
  output logic                       status
);
  import dri_pkg::*;

  cfg_t cfg;
  pos_t item_in;
  pos_t q_item;
  logic q_valid;
  logic pop;

  assign cfg_ready = 1'b1;
  assign item_in   = '{x: x_pos, y: y_pos, z: z_pos};

  // Geometry and scaling registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active   <= RST_ACTIVE;
      cfg.passive  <= RST_PASSIVE;
      cfg.base     <= RST_BASE;
      cfg.platform <= RST_PLATFORM;
      cfg.ppr      <= RST_PPR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE:   cfg.active   <= cfg_data[LEN_W-1:0];
        CFG_PASSIVE:  cfg.passive  <= cfg_data[LEN_W-1:0];
        CFG_BASE:     cfg.base     <= cfg_data[LEN_W-1:0];
        CFG_PLATFORM: cfg.platform <= cfg_data[LEN_W-1:0];
        CFG_PPR:      cfg.ppr      <= cfg_data;
        default:      ;
      endcase
    end
  end

  dri_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item_in(item_in),
    .pop    (pop),
    .q_valid(q_valid),
    .q_item (q_item)
  );

  dri_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .done        (done),
    .angle_one   (angle_one),
    .angle_two   (angle_two),
    .angle_three (angle_three),
    .pulses_one  (pulses_one),
    .pulses_two  (pulses_two),
    .pulses_three(pulses_three),
    .status      (status)
  );

endmodule

[rtl/core/dri_front.sv]
// Front end: command handshake and a two-entry position queue
module dri_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dri_pkg::pos_t item_in,
  input  logic          pop,
  output logic          q_valid,
  output dri_pkg::pos_t q_item
);
  import dri_pkg::*;

  localparam int DEPTH = 2;

  pos_t       entry [0:DEPTH-1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;

  assign busy    = (count == 2'(DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = entry[rd_ptr];

  // Track fill level
  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
    end
  end

  // Store accepted item
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= item_in;
  end

endmodule

[rtl/core/dri_isqrt.sv]
// Pipelined integer square root, one result bit per stage
module dri_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [dri_pkg::RAD_W-1:0]   rad,
  input  dri_pkg::root_side_t         side_in,
  output logic                        out_valid,
  output logic [dri_pkg::ROOT_W-1:0]  root,
  output dri_pkg::root_side_t         side_out
);
  import dri_pkg::*;

  logic [ROOT_W:0]     v;
  logic [RAD_W-1:0]    rem [0:ROOT_W];
  logic [ROOT_W-1:0]   rt  [0:ROOT_W];
  root_side_t          sd  [0:ROOT_W];

  assign v[0]   = in_valid;
  assign rem[0] = rad;
  assign rt[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W:0] trial;
    logic           take;

    // Trial square growth for setting bit B: (root << (B+1)) + 4^B
    assign trial = ({(RAD_W + 1 - ROOT_W)'(0), rt[k]} << (B + 1))
                 | ((RAD_W + 1)'(1) << (2 * B));
    assign take  = ({1'b0, rem[k]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else     v[k+1] <= v[k];
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= take ? (rem[k] - trial[RAD_W-1:0]) : rem[k];
      rt[k+1]  <= take ? (rt[k] | (ROOT_W'(1) << B)) : rt[k];
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = v[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = sd[ROOT_W];

endmodule

[rtl/core/dri_atan.sv]
// Angle unit: sign fix, normalizing shifts, vectoring CORDIC, degree scaling
module dri_atan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [dri_pkg::ROOT_W-1:0]  root,
  input  dri_pkg::root_side_t         side_in,
  output logic                        out_valid,
  output logic [dri_pkg::ANG_W-1:0]   angle,
  output dri_pkg::tag_t               tag_out
);
  import dri_pkg::*;

  localparam int NSH = 6;
  localparam int NUM_W = 48;

  // Numerator and denominator with positive denominator
  logic signed [NUM_W-1:0] num_s;
  logic signed [NUM_W-1:0] den_s;
  logic signed [NUM_W-1:0] num_adj;
  logic signed [NUM_W-1:0] den_adj;
  logic [NUM_W-1:0]        num_mag;

  always_comb begin
    num_s = $signed({{(NUM_W - ROOT_W){1'b0}}, root}) - NUM_W'(side_in.twoa);
    den_s = NUM_W'(side_in.den);
    if (den_s < 0) begin
      num_adj = -num_s;
      den_adj = -den_s;
    end else begin
      num_adj = num_s;
      den_adj = den_s;
    end
    num_mag = num_adj[NUM_W-1] ? NUM_W'(-num_adj) : NUM_W'(num_adj);
  end

  logic [NSH:0]      n_v;
  tag_t              n_tag [0:NSH];
  logic              n_neg [0:NSH];
  logic [NORM_W-1:0] n_nm  [0:NSH];
  logic [NORM_W-1:0] n_dm  [0:NSH];
  logic [NORM_W-1:0] n_big [0:NSH];

  // Register the sign-fixed magnitudes
  always_ff @(posedge clk) begin
    if (rst) n_v[0] <= 1'b0;
    else     n_v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    n_tag[0] <= side_in.tag;
    n_neg[0] <= num_adj[NUM_W-1];
    n_nm[0]  <= NORM_W'(num_mag);
    n_dm[0]  <= NORM_W'(den_adj);
    n_big[0] <= (num_mag > NUM_W'(den_adj)) ? NORM_W'(num_mag) : NORM_W'(den_adj);
  end

  // Shift until the larger magnitude reaches bit NORM_W-1
  for (genvar j = 0; j < NSH; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic do_shift;
    assign do_shift = (n_big[j][NORM_W-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) n_v[j+1] <= 1'b0;
      else     n_v[j+1] <= n_v[j];
    end

    always_ff @(posedge clk) begin
      n_tag[j+1] <= n_tag[j];
      n_neg[j+1] <= n_neg[j];
      n_nm[j+1]  <= do_shift ? (n_nm[j] << SH)  : n_nm[j];
      n_dm[j+1]  <= do_shift ? (n_dm[j] << SH)  : n_dm[j];
      n_big[j+1] <= do_shift ? (n_big[j] << SH) : n_big[j];
    end
  end

  logic [CORDIC_STEPS:0]   c_v;
  tag_t                    c_tag [0:CORDIC_STEPS];
  logic signed [CX_W-1:0]  c_x   [0:CORDIC_STEPS];
  logic signed [CX_W-1:0]  c_y   [0:CORDIC_STEPS];
  logic signed [PHI_W-1:0] c_phi [0:CORDIC_STEPS];

  assign c_v[0]   = n_v[NSH];
  assign c_tag[0] = n_tag[NSH];
  assign c_x[0]   = $signed({{(CX_W - NORM_W){1'b0}}, n_dm[NSH]});
  assign c_y[0]   = n_neg[NSH] ? -$signed({{(CX_W - NORM_W){1'b0}}, n_nm[NSH]})
                               :  $signed({{(CX_W - NORM_W){1'b0}}, n_nm[NSH]});
  assign c_phi[0] = '0;

  // Rotate toward the x axis, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0]  xs;
    logic signed [CX_W-1:0]  ys;
    logic signed [PHI_W-1:0] step;

    assign xs   = c_x[i] >>> i;
    assign ys   = c_y[i] >>> i;
    assign step = $signed(atan_q16(i));

    always_ff @(posedge clk) begin
      if (rst) c_v[i+1] <= 1'b0;
      else     c_v[i+1] <= c_v[i];
    end

    always_ff @(posedge clk) begin
      c_tag[i+1] <= c_tag[i];
      if (!c_y[i][CX_W-1]) begin
        c_x[i+1]   <= c_x[i] + ys;
        c_y[i+1]   <= c_y[i] - xs;
        c_phi[i+1] <= c_phi[i] + step;
      end else begin
        c_x[i+1]   <= c_x[i] - ys;
        c_y[i+1]   <= c_y[i] + xs;
        c_phi[i+1] <= c_phi[i] - step;
      end
    end
  end

  // Angle = 180 - 2*atan, to 1/1024 degree with rounding, then clamp
  logic signed [27:0] w_full;
  logic signed [27:0] w_sh;
  logic [ANG_W-1:0]   w_clamp;

  always_comb begin
    w_full = 28'sd5898256 - 28'(c_phi[CORDIC_STEPS]);
    w_sh   = w_full >>> 5;
    if (w_sh < 0)
      w_clamp = '0;
    else if (w_sh > $signed({9'd0, FULL_TURN_Q}))
      w_clamp = FULL_TURN_Q;
    else
      w_clamp = w_sh[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= c_v[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    tag_out <= c_tag[CORDIC_STEPS];
    angle   <= c_tag[CORDIC_STEPS].fail ? '0 : w_clamp;
  end

endmodule

[rtl/core/dri_back.sv]
// Back end: arm issue, quadratic setup, root and angle units, pulses, result collect
module dri_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dri_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  dri_pkg::pos_t              q_item,
  output logic                       pop,
  output logic                       done,
  output logic [dri_pkg::ANG_W-1:0]  angle_one,
  output logic [dri_pkg::ANG_W-1:0]  angle_two,
  output logic [dri_pkg::ANG_W-1:0]  angle_three,
  output logic [dri_pkg::PUL_W-1:0]  pulses_one,
  output logic [dri_pkg::PUL_W-1:0]  pulses_two,
  output logic [dri_pkg::PUL_W-1:0]  pulses_three,
  output logic                       status
);
  import dri_pkg::*;

  // Issue: one arm per cycle, three per position
  logic act;
  arm_t cnt;
  pos_t cur;

  assign pop = q_valid && (!act || (cnt == ARM_THREE));

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      cnt <= ARM_ONE;
    end else if (pop) begin
      act <= 1'b1;
      cnt <= ARM_ONE;
    end else if (act) begin
      if (cnt == ARM_THREE) act <= 1'b0;
      else                  cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
  end

  // Stage 1: first-level products
  logic signed [21:0] m_c;
  logic signed [21:0] p_c;
  logic signed [19:0] len_s;

  assign len_s = $signed({1'b0, cfg.active});
  assign m_c   = $signed({3'b0, cfg.active}) - $signed({3'b0, cfg.base})
               + $signed({3'b0, cfg.platform});
  assign p_c   = $signed({3'b0, cfg.active}) + $signed({3'b0, cfg.base})
               - $signed({3'b0, cfg.platform});

  logic [7:1]               sv;
  arm_t                     s1_arm;
  logic signed [37:0]       s1_xc, s1_ys;
  logic signed [40:0]       s1_xx, s1_yy, s1_zz;
  logic [37:0]              s1_bb;
  logic signed [TWOA_W-1:0] s1_twoa;
  logic signed [21:0]       s1_m, s1_p;
  logic signed [43:0]       s1_mm, s1_pp;

  always_ff @(posedge clk) begin
    if (rst) sv <= '0;
    else     sv <= {sv[6:1], act};
  end

  always_ff @(posedge clk) begin
    s1_arm  <= cnt;
    s1_xc   <= cur.x * cos_q16(cnt);
    s1_ys   <= cur.y * sin_q16(cnt);
    s1_xx   <= cur.x * cur.x;
    s1_yy   <= cur.y * cur.y;
    s1_zz   <= cur.z * cur.z;
    s1_bb   <= cfg.passive * cfg.passive;
    s1_twoa <= (len_s * cur.z) <<< 1;
    s1_m    <= m_c;
    s1_p    <= p_c;
    s1_mm   <= m_c * m_c;
    s1_pp   <= p_c * p_c;
  end

  // Stage 2: projected radius u and B^2 - r^2
  logic signed [38:0]       u_sum;
  logic signed [38:0]       u_sh;
  arm_t                     s2_arm;
  logic signed [21:0]       s2_u;
  logic signed [42:0]       s2_base;
  logic signed [TWOA_W-1:0] s2_twoa;
  logic signed [21:0]       s2_m, s2_p;
  logic signed [43:0]       s2_mm, s2_pp;

  assign u_sum = 39'(s1_xc) + 39'(s1_ys) + 39'sd32768;
  assign u_sh  = u_sum >>> 16;

  always_ff @(posedge clk) begin
    s2_arm  <= s1_arm;
    s2_u    <= u_sh[21:0];
    s2_base <= $signed({5'b0, s1_bb}) - (43'(s1_xx) + 43'(s1_yy) + 43'(s1_zz));
    s2_twoa <= s1_twoa;
    s2_m    <= s1_m;
    s2_p    <= s1_p;
    s2_mm   <= s1_mm;
    s2_pp   <= s1_pp;
  end

  // Stage 3: cross terms
  arm_t                     s3_arm;
  logic signed [43:0]       s3_mu, s3_pu;
  logic signed [42:0]       s3_base;
  logic signed [TWOA_W-1:0] s3_twoa;
  logic signed [43:0]       s3_mm, s3_pp;

  always_ff @(posedge clk) begin
    s3_arm  <= s2_arm;
    s3_mu   <= s2_m * s2_u;
    s3_pu   <= s2_p * s2_u;
    s3_base <= s2_base;
    s3_twoa <= s2_twoa;
    s3_mm   <= s2_mm;
    s3_pp   <= s2_pp;
  end

  // Stage 4: quadratic coefficients P and Q
  arm_t                     s4_arm;
  logic signed [P_W-1:0]    s4_p, s4_q;
  logic signed [TWOA_W-1:0] s4_twoa;

  always_ff @(posedge clk) begin
    s4_arm  <= s3_arm;
    s4_p    <= P_W'(s3_base) - P_W'(s3_mm) - (P_W'(s3_mu) <<< 1);
    s4_q    <= P_W'(s3_base) - P_W'(s3_pp) + (P_W'(s3_pu) <<< 1);
    s4_twoa <= s3_twoa;
  end

  // Stage 5: partial products of P*Q and (2Lz)^2
  logic signed [23:0]       q_lo;
  logic signed [22:0]       q_hi;
  logic signed [21:0]       a_lo;
  logic signed [19:0]       a_hi;
  arm_t                     s5_arm;
  logic signed [69:0]       s5_pq_lo;
  logic signed [68:0]       s5_pq_hi;
  logic signed [62:0]       s5_sq_lo;
  logic signed [60:0]       s5_sq_hi;
  logic signed [P_W-1:0]    s5_p;
  logic signed [TWOA_W-1:0] s5_twoa;

  assign q_lo = $signed({1'b0, s4_q[22:0]});
  assign q_hi = s4_q[P_W-1:23];
  assign a_lo = $signed({1'b0, s4_twoa[20:0]});
  assign a_hi = s4_twoa[TWOA_W-1:21];

  always_ff @(posedge clk) begin
    s5_arm   <= s4_arm;
    s5_pq_lo <= s4_p * q_lo;
    s5_pq_hi <= s4_p * q_hi;
    s5_sq_lo <= s4_twoa * a_lo;
    s5_sq_hi <= s4_twoa * a_hi;
    s5_p     <= s4_p;
    s5_twoa  <= s4_twoa;
  end

  // Stage 6: combine partial products
  arm_t                     s6_arm;
  logic signed [92:0]       s6_pq, s6_sq;
  logic signed [P_W-1:0]    s6_p;
  logic signed [TWOA_W-1:0] s6_twoa;

  always_ff @(posedge clk) begin
    s6_arm  <= s5_arm;
    s6_pq   <= 93'(s5_pq_lo) + (93'(s5_pq_hi) <<< 23);
    s6_sq   <= 93'(s5_sq_lo) + (93'(s5_sq_hi) <<< 21);
    s6_p    <= s5_p;
    s6_twoa <= s5_twoa;
  end

  // Stage 7: discriminant and reach check
  logic signed [92:0] disc;
  logic               unreach;
  logic [RAD_W-1:0]   s7_rad;
  root_side_t         s7_side;

  assign disc    = s6_sq - s6_pq;
  assign unreach = disc[92] || (s6_p == '0);

  always_ff @(posedge clk) begin
    s7_rad            <= unreach ? '0 : disc[RAD_W-1:0];
    s7_side.tag.arm   <= s6_arm;
    s7_side.tag.fail  <= unreach;
    s7_side.den       <= s6_p;
    s7_side.twoa      <= s6_twoa;
  end

  // Root and angle units
  logic               r_valid;
  logic [ROOT_W-1:0]  r_root;
  root_side_t         r_side;
  logic               g_valid;
  logic [ANG_W-1:0]   g_angle;
  tag_t               g_tag;

  dri_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sv[7]),
    .rad      (s7_rad),
    .side_in  (s7_side),
    .out_valid(r_valid),
    .root     (r_root),
    .side_out (r_side)
  );

  dri_atan u_atan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r_valid),
    .root     (r_root),
    .side_in  (r_side),
    .out_valid(g_valid),
    .angle    (g_angle),
    .tag_out  (g_tag)
  );

  // Pulses: product, reciprocal multiply, remainder, correction
  logic             pa_v, pb_v, pc_v, pd_v;
  tag_t             pa_tag, pb_tag, pc_tag, pd_tag;
  logic [ANG_W-1:0] pa_ang, pb_ang, pc_ang, pd_ang;
  logic [38:0]      pa_prod;
  logic [25:0]      pb_n;
  logic [52:0]      pb_t;
  logic [20:0]      pc_q0;
  logic [6:0]       pc_r;
  logic [PUL_W-1:0] pd_pul;
  logic [26:0]      rem_full;
  logic [20:0]      q_fix;

  assign rem_full = 27'(pb_n) - 27'(pb_t[52:32]) * DIV_CONST;
  assign q_fix    = (27'(pc_r) >= DIV_CONST) ? (pc_q0 + 21'd1) : pc_q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v <= 1'b0;
      pb_v <= 1'b0;
      pc_v <= 1'b0;
      pd_v <= 1'b0;
    end else begin
      pa_v <= g_valid;
      pb_v <= pa_v;
      pc_v <= pb_v;
      pd_v <= pc_v;
    end
  end

  always_ff @(posedge clk) begin
    pa_tag  <= g_tag;
    pa_ang  <= g_angle;
    pa_prod <= g_angle * cfg.ppr;
    pb_tag  <= pa_tag;
    pb_ang  <= pa_ang;
    pb_n    <= pa_prod[38:PUL_SHIFT];
    pb_t    <= pa_prod[38:PUL_SHIFT] * DIV_RECIP;
    pc_tag  <= pb_tag;
    pc_ang  <= pb_ang;
    pc_q0   <= pb_t[52:32];
    pc_r    <= rem_full[6:0];
    pd_tag  <= pc_tag;
    pd_ang  <= pc_ang;
    pd_pul  <= q_fix[PUL_W-1:0];
  end

  // Collect three arms; zero every arm from the first unreachable one on
  logic             dead;
  logic [ANG_W-1:0] acc_a1, acc_a2;
  logic [PUL_W-1:0] acc_p1, acc_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      dead <= 1'b0;
    end else begin
      done <= 1'b0;
      if (pd_v) begin
        case (pd_tag.arm)
          ARM_ONE: dead <= pd_tag.fail;
          ARM_TWO: dead <= dead || pd_tag.fail;
          default: done <= 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pd_v) begin
      case (pd_tag.arm)
        ARM_ONE: begin
          acc_a1 <= pd_ang;
          acc_p1 <= pd_pul;
        end
        ARM_TWO: begin
          acc_a2 <= dead ? '0 : pd_ang;
          acc_p2 <= dead ? '0 : pd_pul;
        end
        default: begin
          angle_one    <= acc_a1;
          pulses_one   <= acc_p1;
          angle_two    <= acc_a2;
          pulses_two   <= acc_p2;
          angle_three  <= dead ? '0 : pd_ang;
          pulses_three <= dead ? '0 : pd_pul;
          status       <= dead || pd_tag.fail;
        end
      endcase
    end
  end

endmodule

[rtl/core/dri_checker.sv]
// Port-level checks for the kinematics core and their binding
`include "assert_macros.svh"

module dri_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       busy,
  input logic                       done,
  input logic [dri_pkg::ANG_W-1:0]  angle_one,
  input logic [dri_pkg::ANG_W-1:0]  angle_two,
  input logic [dri_pkg::ANG_W-1:0]  angle_three,
  input logic [dri_pkg::PUL_W-1:0]  pulses_three,
  input logic                       status
);
  import dri_pkg::*;

  logic in_range;

  assign in_range = (angle_one <= FULL_TURN_Q) && (angle_two <= FULL_TURN_Q)
                 && (angle_three <= FULL_TURN_Q);

  // Done never rises on back-to-back cycles
  `DRI_ASSERT_NXT(a_done_gap, done, !done)
  // An unreachable position always zeroes the last arm
  `DRI_ASSERT_IMP(a_last_zero, done && status, angle_three == '0 && pulses_three == '0)
  // Angles stay within one turn
  `DRI_ASSERT_IMP(a_angle_range, done, in_range)
  // Reset leaves the queue open and done low
  `DRI_ASSERT_RST(a_reset_idle, rst, !busy && !done)

endmodule

bind delta_robot_inverse_kinematics dri_checker u_chk (.*);

[sim/delta_robot_inverse_kinematics_tb.sv]
// Self-checking testbench for the delta robot inverse kinematics core
module delta_robot_inverse_kinematics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dri_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;
  localparam longint HALF_TURN_Q5 = 184320 * 32;
  localparam longint FULL_TURN = 368640;

  typedef struct {
    logic signed [POS_W-1:0] x, y, z;
  } position_t;

  typedef struct {
    logic [ANG_W-1:0] angle [3];
    logic [PUL_W-1:0] pulses [3];
    logic             status;
  } joint_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [POS_W-1:0] x_pos = '0, y_pos = '0, z_pos = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [PPR_W-1:0] cfg_data = '0;
  logic done;
  logic [ANG_W-1:0] angle_one, angle_two, angle_three;
  logic [PUL_W-1:0] pulses_one, pulses_two, pulses_three;
  logic status;

  delta_robot_inverse_kinematics u_top (.*);

  // geometry copy kept by the predictor
  longint geo_active, geo_passive, geo_base, geo_platform, geo_ppr;

  position_t pending_positions [$];
  joint_set_t expected_joints [$];
  int errors = 0;
  int solved_count = 0, unreachable_count = 0, cfg_count = 0;
  int idle_cycles = 0;
  int burst_left = 0, gap_left = 0;

  longint atan_table [CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Solve one arm; return 0 when the position is out of reach for it
  function automatic bit solve_joint(int arm, longint x, longint y, longint z,
                                     output longint ang);
    longint c, s, u, r2, m, p, pp, qq, twoa, num, den, cx, cy, phi, w, xs, ys;
    logic [127:0] sq, pq, disc, cand, ta, pm, qm;
    longint root;
    logic [63:0] nm, dm, big;
    int sh;
    ang = 0;
    case (arm)
      0: begin c = 56756; s = 32768; end
      1: begin c = -56756; s = 32768; end
      default: begin c = 0; s = -65536; end
    endcase
    u = (x * c + y * s + 32768) >>> 16;
    r2 = x * x + y * y + z * z;
    m = geo_active - (geo_base - geo_platform);
    p = geo_active + (geo_base - geo_platform);
    pp = geo_passive * geo_passive - r2 - m * m - 2 * m * u;
    qq = geo_passive * geo_passive - r2 - p * p + 2 * p * u;
    twoa = 2 * geo_active * z;
    ta = magnitude(twoa);
    pm = magnitude(pp);
    qm = magnitude(qq);
    sq = ta * ta;
    pq = pm * qm;
    if (pp == 0) return 1'b0;
    if ((pp < 0) != (qq < 0) && qq != 0) disc = sq + pq;
    else if (sq < pq) return 1'b0;
    else disc = sq - pq;
    root = 0;
    for (int b = 43; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= disc) root = cand;
    end
    num = root - twoa;
    den = pp;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    nm = magnitude(num);
    dm = den;
    big = nm > dm ? nm : dm;
    sh = 0;
    while (big < (64'd1 << 58)) begin
      big = big << 1;
      sh++;
    end
    cx = dm << sh;
    cy = nm << sh;
    if (num < 0) cy = -cy;
    phi = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx += ys; cy -= xs; phi += atan_table[i];
      end else begin
        cx -= ys; cy += xs; phi -= atan_table[i];
      end
    end
    w = (HALF_TURN_Q5 - phi + 16) >>> 5;
    if (w < 0) w = 0;
    if (w > FULL_TURN) w = FULL_TURN;
    ang = w;
    return 1'b1;
  endfunction

  function automatic joint_set_t predict_joints(position_t pos);
    joint_set_t js;
    longint ang [3];
    longint a;
    ang = '{0, 0, 0};
    js.status = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!solve_joint(k, pos.x, pos.y, pos.z, a)) begin
        js.status = 1'b1;
        break;
      end
      ang[k] = a;
    end
    for (int k = 0; k < 3; k++) begin
      js.angle[k] = ang[k];
      js.pulses[k] = (ang[k] * geo_ppr) / FULL_TURN;
    end
    return js;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Driver: issue pending positions in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the offered item until accepted
    end else begin
      if (start) begin
        expected_joints.push_back(predict_joints(pending_positions.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_positions.size() > 0) begin
        start <= 1'b1;
        x_pos <= pending_positions[0].x;
        y_pos <= pending_positions[0].y;
        z_pos <= pending_positions[0].z;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: track geometry writes and check each done strobe
  always @(posedge clk) begin
    joint_set_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_count++;
        case (cfg_index)
          CFG_ACTIVE:   geo_active = cfg_data[LEN_W-1:0];
          CFG_PASSIVE:  geo_passive = cfg_data[LEN_W-1:0];
          CFG_BASE:     geo_base = cfg_data[LEN_W-1:0];
          CFG_PLATFORM: geo_platform = cfg_data[LEN_W-1:0];
          CFG_PPR:      geo_ppr = cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (expected_joints.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_joints.pop_front();
          if (want.status) unreachable_count++;
          else solved_count++;
          if (angle_one !== want.angle[0]) report_mismatch("angle_one", angle_one, want.angle[0]);
          if (angle_two !== want.angle[1]) report_mismatch("angle_two", angle_two, want.angle[1]);
          if (angle_three !== want.angle[2])
            report_mismatch("angle_three", angle_three, want.angle[2]);
          if (pulses_one !== want.pulses[0])
            report_mismatch("pulses_one", pulses_one, want.pulses[0]);
          if (pulses_two !== want.pulses[1])
            report_mismatch("pulses_two", pulses_two, want.pulses[1]);
          if (pulses_three !== want.pulses[2])
            report_mismatch("pulses_three", pulses_three, want.pulses[2]);
          if (status !== want.status) report_mismatch("status", status, want.status);
        end
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("delta_robot_inverse_kinematics_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_geometry(logic [2:0] idx, logic [PPR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(longint act, longint pas, longint bas, longint plat, longint ppr);
    write_geometry(CFG_ACTIVE, act);
    write_geometry(CFG_PASSIVE, pas);
    write_geometry(CFG_BASE, bas);
    write_geometry(CFG_PLATFORM, plat);
    write_geometry(CFG_PPR, ppr);
  endtask

  task automatic queue_position(longint x, longint y, longint z);
    position_t pos;
    pos.x = x;
    pos.y = y;
    pos.z = z;
    pending_positions.push_back(pos);
  endtask

  // Mostly positions inside the work envelope, some anywhere in the field range
  task automatic queue_random(int count, int reach);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        queue_position($signed(POS_W'($urandom)), $signed(POS_W'($urandom)),
                       $signed(POS_W'($urandom)));
      else
        queue_position($signed($urandom_range(0, 2 * reach)) - reach,
                       $signed($urandom_range(0, 2 * reach)) - reach,
                       -$signed($urandom_range(reach / 4, 2 * reach)));
    end
  endtask

  task automatic drain();
    wait (pending_positions.size() == 0 && expected_joints.size() == 0 && !start);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    geo_active = RST_ACTIVE;
    geo_passive = RST_PASSIVE;
    geo_base = RST_BASE;
    geo_platform = RST_PLATFORM;
    geo_ppr = RST_PPR;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed positions at default geometry: field extremes and reach limits
    queue_position(0, 0, -76800);
    queue_position(0, 0, 0);
    queue_position(-524288, -524288, -524288);
    queue_position(524287, 524287, 524287);
    queue_position(524287, 0, -76800);
    queue_position(-524288, 0, -76800);
    queue_position(0, 524287, -76800);
    queue_position(0, -524288, -76800);
    queue_position(0, 0, -524288);
    queue_position(0, 0, 524287);
    queue_position(25600, 25600, -64000);
    queue_position(-25600, 12800, -102400);
    queue_position(0, -51200, -89600);
    queue_position(-51200, 0, -89600);
    queue_position(51200, 0, -89600);
    queue_position(0, 0, -180000);
    queue_position(-1, -1, -1);
    queue_position(1, 1, 1);
    queue_random(450, 60000);
    drain();

    // Zero geometry: zero denominator at the origin, zero pulses per turn
    set_geometry(0, 0, 0, 0, 0);
    write_geometry(CFG_UNUSED, 20'hFFFFF);
    queue_position(0, 0, 0);
    queue_position(256, 0, 0);
    queue_random(100, 60000);
    drain();

    // Largest geometry and pulse count
    set_geometry(524287, 524287, 524287, 524287, 20'hFFFFF);
    queue_position(0, 0, 0);
    queue_random(300, 200000);
    drain();

    // Random plausible geometry with one pulse per turn, then random raw values
    set_geometry($urandom_range(20000, 120000), $urandom_range(100000, 300000),
                 $urandom_range(20000, 80000), $urandom_range(1000, 30000), 1);
    queue_random(450, 60000);
    drain();
    set_geometry(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                 POS_W'($urandom), POS_W'($urandom));
    queue_random(200, 200000);
    drain();
    set_geometry(RST_ACTIVE, RST_PASSIVE, RST_BASE, RST_PLATFORM, 1000000);
    queue_random(300, 60000);
    drain();

    $display("covered %0d reachable and %0d unreachable positions over %0d register writes",
             solved_count, unreachable_count, cfg_count);
    if (errors == 0) begin
      $display("delta_robot_inverse_kinematics_tb: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("delta_robot_inverse_kinematics_tb: FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/dri_pkg.sv
rtl/core/dri_front.sv
rtl/core/dri_isqrt.sv
rtl/core/dri_atan.sv
rtl/core/dri_back.sv
rtl/core/delta_robot_inverse_kinematics.sv
rtl/core/dri_checker.sv
sim/delta_robot_inverse_kinematics_tb.sv
